@@ src/tmsa_pkg.sv @@
// shared widths, reset values and defaults for the trimmed-mean sample averager
package tmsa_pkg;

    localparam int SAMPLE_BITS    = 12;
    localparam int COUNT_BITS     = 8;
    localparam int AVG_BITS       = 12;
    localparam int SUM_BITS       = SAMPLE_BITS + COUNT_BITS;
    localparam int WARMUP_DEFAULT = 4;

    localparam logic [COUNT_BITS-1:0]  SAMPLE_COUNT_RESET = COUNT_BITS'(8);
    localparam logic [SAMPLE_BITS-1:0] SMALLEST_RESET     = {SAMPLE_BITS{1'b1}};

endpackage

@@ src/tmsa_div.sv @@
// restoring divider, one quotient bit per cycle
module tmsa_div #(
    parameter int DIVIDEND_BITS = tmsa_pkg::SUM_BITS,
    parameter int DIVISOR_BITS  = tmsa_pkg::COUNT_BITS
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [DIVIDEND_BITS-1:0] dividend,
    input  logic [DIVISOR_BITS-1:0]  divisor,
    output logic                     done,
    output logic [DIVIDEND_BITS-1:0] quotient
);

    localparam int CNT_BITS = $clog2(DIVIDEND_BITS);
    localparam logic [CNT_BITS-1:0] LAST_STEP = CNT_BITS'(DIVIDEND_BITS - 1);

    logic                     busy_reg, busy_next;
    logic                     done_reg, done_next;
    logic [CNT_BITS-1:0]      cnt_reg, cnt_next;
    logic [DIVISOR_BITS-1:0]  rem_reg, rem_next;
    logic [DIVISOR_BITS-1:0]  dvs_reg, dvs_next;
    logic [DIVIDEND_BITS-1:0] quo_reg, quo_next;
    logic [DIVISOR_BITS:0]    shifted;
    logic                     fits;

    assign shifted = {rem_reg, quo_reg[DIVIDEND_BITS-1]};
    assign fits    = shifted >= {1'b0, dvs_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        quo_next  = quo_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            dvs_next  = divisor;
            quo_next  = dividend;
        end
        else if (busy_reg)
        begin
            if (fits)
                rem_next = DIVISOR_BITS'(shifted - {1'b0, dvs_reg});
            else
                rem_next = shifted[DIVISOR_BITS-1:0];
            quo_next = {quo_reg[DIVIDEND_BITS-2:0], fits};
            cnt_next = cnt_reg + CNT_BITS'(1);
            if (cnt_reg == LAST_STEP)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        quo_reg <= quo_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

@@ src/trimmed_mean_sample_averager.sv @@
// top level: warm-up discard, running sum/max/min and trimmed-mean result
// Each batch drops WARMUP_DISCARDS samples, then measures sample_count samples
// (0 is taken as 1); a zero sample counts toward the batch but is not summed.
// A sample that does not end a batch is taken without a stall. The last sample
// of a batch stalls the input through a setup state, the bit-serial divider
// (one quotient bit per step for SUM_BITS bits), its done flag and the load of
// the result register; the stall lasts longer if the previous result is still
// stalled. The result register lets a new batch begin while a result waits.
// With more than two measured samples the result is (sum - max - min) /
// (sample_count - 2), saturating at 0, else sum / sample_count; a batch with
// no nonzero sample gives 0 and raises no_valid_samples. The sample_count
// register may be written while no divide is running; a write that comes with
// a sample already applies to that sample.
module trimmed_mean_sample_averager #(
    parameter int WARMUP_DISCARDS = tmsa_pkg::WARMUP_DEFAULT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [tmsa_pkg::SAMPLE_BITS-1:0] sample,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [tmsa_pkg::COUNT_BITS-1:0]  sample_count,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [tmsa_pkg::AVG_BITS-1:0]    average,
    output logic                             no_valid_samples
);

    localparam int SB = tmsa_pkg::SAMPLE_BITS;
    localparam int CB = tmsa_pkg::COUNT_BITS;
    localparam int AB = tmsa_pkg::AVG_BITS;
    localparam int UB = tmsa_pkg::SUM_BITS;
    localparam int POS_BITS = $clog2(WARMUP_DISCARDS + (1 << CB));
    localparam int END_BITS = POS_BITS + 1;
    localparam logic [END_BITS-1:0] WARMUP_W = END_BITS'(WARMUP_DISCARDS);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_PREP = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    logic [1:0]          state_reg, state_next;
    logic [POS_BITS-1:0] pos_reg, pos_next;
    logic [UB-1:0]       sum_reg, sum_next;
    logic [SB-1:0]       max_reg, max_next;
    logic [SB-1:0]       min_reg, min_next;
    logic                any_reg, any_next;
    logic [CB-1:0]       count_reg, count_next;
    logic                nv_reg, nv_next;
    logic                out_valid_reg, out_valid_next;
    logic [AB-1:0]       avg_reg, avg_next;
    logic                nv_out_reg, nv_out_next;

    logic                accept;
    logic [CB-1:0]       count_eff;
    logic [CB-1:0]       n_eff;
    logic                measure;
    logic                batch_end;
    logic [SB:0]         trim;
    logic                trim_ok;
    logic                div_start;
    logic [UB-1:0]       div_dividend;
    logic [CB-1:0]       div_divisor;
    logic                div_done;
    logic [UB-1:0]       div_quotient;

    assign accept    = in_valid && !in_stall;
    assign in_stall  = state_reg != ST_IDLE;
    assign cfg_ready = state_reg == ST_IDLE;
    assign count_eff = (cfg_valid && cfg_ready) ? sample_count : count_reg;
    assign n_eff     = (count_eff == '0) ? CB'(1) : count_eff;
    assign measure   = (END_BITS'(pos_reg) >= WARMUP_W) && (sample != '0);
    assign batch_end = (END_BITS'(pos_reg) + END_BITS'(1)) >= (WARMUP_W + END_BITS'(n_eff));
    assign trim      = {1'b0, max_reg} + {1'b0, min_reg};
    assign trim_ok   = sum_reg >= UB'(trim);

    always_comb
    begin
        if (!any_reg)
            div_dividend = '0;
        else if (n_eff > CB'(2))
            div_dividend = trim_ok ? (sum_reg - UB'(trim)) : '0;
        else
            div_dividend = sum_reg;
        div_divisor = (n_eff > CB'(2)) ? (n_eff - CB'(2)) : n_eff;
    end

    always_comb
    begin
        state_next     = state_reg;
        pos_next       = pos_reg;
        sum_next       = sum_reg;
        max_next       = max_reg;
        min_next       = min_reg;
        any_next       = any_reg;
        nv_next        = nv_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg && out_stall;
        avg_next       = avg_reg;
        nv_out_next    = nv_out_reg;
        div_start      = 1'b0;
        if (cfg_valid && cfg_ready)
            count_next = sample_count;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (measure)
                    begin
                        sum_next = sum_reg + UB'(sample);
                        if (sample > max_reg)
                            max_next = sample;
                        if (sample < min_reg)
                            min_next = sample;
                        any_next = 1'b1;
                    end
                    if (batch_end)
                        state_next = ST_PREP;
                    else
                        pos_next = pos_reg + POS_BITS'(1);
                end
            end
            ST_PREP:
            begin
                div_start  = 1'b1;
                nv_next    = !any_reg;
                pos_next   = '0;
                sum_next   = '0;
                max_next   = '0;
                min_next   = tmsa_pkg::SMALLEST_RESET;
                any_next   = 1'b0;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_done)
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                // result register free or being taken this cycle
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    avg_next       = div_quotient[AB-1:0];
                    nv_out_next    = nv_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pos_reg       <= '0;
            sum_reg       <= '0;
            max_reg       <= '0;
            min_reg       <= tmsa_pkg::SMALLEST_RESET;
            any_reg       <= 1'b0;
            count_reg     <= tmsa_pkg::SAMPLE_COUNT_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            sum_reg       <= sum_next;
            max_reg       <= max_next;
            min_reg       <= min_next;
            any_reg       <= any_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        nv_reg     <= nv_next;
        avg_reg    <= avg_next;
        nv_out_reg <= nv_out_next;
    end

    tmsa_div #(
        .DIVIDEND_BITS (UB),
        .DIVISOR_BITS  (CB)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quotient)
    );

    assign out_valid        = out_valid_reg;
    assign average          = avg_reg;
    assign no_valid_samples = nv_out_reg;

    // divider finishes only while the sequencer waits for it
    assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == ST_DIV)
        else $error("divider done outside divide state");

    // setup always hands a request to the divider and clears the batch
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_PREP |=> state_reg == ST_DIV && pos_reg == '0 && !any_reg)
        else $error("batch not cleared after setup");

    // an empty batch reports a zero average
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && no_valid_samples |-> average == '0)
        else $error("nonzero average with no valid samples");

    // a new result is loaded only into a free or draining result register
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DONE && out_valid_reg && out_stall |=> state_reg == ST_DONE)
        else $error("result overwritten while stalled");

endmodule

@@ dv/trimmed_mean_checker.sv @@
// checker for the trimmed-mean sample averager: predicts each batch result and compares
`timescale 1ns / 1ps

module trimmed_mean_checker (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    input  logic                             in_stall,
    input  logic [tmsa_pkg::SAMPLE_BITS-1:0] sample,
    input  logic                             cfg_valid,
    input  logic                             cfg_ready,
    input  logic [tmsa_pkg::COUNT_BITS-1:0]  sample_count,
    input  logic                             out_valid,
    input  logic                             out_stall,
    input  logic [tmsa_pkg::AVG_BITS-1:0]    average,
    input  logic                             no_valid_samples,
    output int unsigned                      error_count,
    output int unsigned                      pending_results
);

    localparam int unsigned WARMUP = tmsa_pkg::WARMUP_DEFAULT;

    typedef struct packed {
        logic [tmsa_pkg::AVG_BITS-1:0] average;
        logic                          no_valid;
    } batch_result_t;

    logic [8:0]                       batch_pos;
    logic [tmsa_pkg::SUM_BITS-1:0]    batch_sum;
    logic [tmsa_pkg::SAMPLE_BITS-1:0] batch_max;
    logic [tmsa_pkg::SAMPLE_BITS-1:0] batch_min;
    logic                             batch_has_valid;
    logic [tmsa_pkg::COUNT_BITS-1:0]  count_setting;

    batch_result_t expected_averages[$];
    batch_result_t predicted;
    batch_result_t oldest;

    function automatic void start_new_batch();
        batch_pos       = '0;
        batch_sum       = '0;
        batch_max       = '0;
        batch_min       = tmsa_pkg::SMALLEST_RESET;
        batch_has_valid = 1'b0;
    endfunction

    function automatic bit fold_sample(input logic [tmsa_pkg::SAMPLE_BITS-1:0] s,
                                       output batch_result_t res);
        int unsigned n;
        int unsigned pos;
        int unsigned trim;
        int unsigned quotient;
        n        = (count_setting == '0) ? 1 : count_setting;
        pos      = batch_pos;
        res      = '0;
        quotient = 0;
        if (pos >= WARMUP && s != '0)
        begin
            batch_sum = batch_sum + s;
            if (s > batch_max)
                batch_max = s;
            if (s < batch_min)
                batch_min = s;
            batch_has_valid = 1'b1;
        end
        if (pos + 1 < WARMUP + n)
        begin
            batch_pos = 9'(pos + 1);
            return 1'b0;
        end
        if (batch_has_valid)
        begin
            if (n > 2)
            begin
                trim     = batch_max + batch_min;
                quotient = (batch_sum >= trim) ? (batch_sum - trim) / (n - 2) : 0;
            end
            else
                quotient = batch_sum / n;
        end
        res.average  = tmsa_pkg::AVG_BITS'(quotient);
        res.no_valid = !batch_has_valid;
        start_new_batch();
        return 1'b1;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_new_batch();
            count_setting = tmsa_pkg::SAMPLE_COUNT_RESET;
            expected_averages.delete();
            error_count = 0;
            pending_results <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                count_setting = sample_count;
            if (in_valid && !in_stall)
            begin
                if (fold_sample(sample, predicted))
                    expected_averages.push_back(predicted);
            end
            if (out_valid && !out_stall)
            begin
                if (expected_averages.size() == 0)
                begin
                    error_count++;
                    if (error_count <= 10)
                        $display("%0t: unexpected result average %0d no_valid_samples %0b",
                                 $time, average, no_valid_samples);
                end
                else
                begin
                    oldest = expected_averages.pop_front();
                    if (average !== oldest.average || no_valid_samples !== oldest.no_valid)
                    begin
                        error_count++;
                        if (error_count <= 10)
                            $display("%0t: mismatch: got %0d/%0b, expected %0d/%0b",
                                     $time, average, no_valid_samples,
                                     oldest.average, oldest.no_valid);
                    end
                end
            end
            pending_results <= expected_averages.size();
        end
    end

endmodule

@@ dv/tb_trimmed_mean_sample_averager.sv @@
// testbench top for the trimmed-mean sample averager: stimulus, idling and verdict
`timescale 1ns / 1ps

module tb_trimmed_mean_sample_averager;

    logic                             clk;
    logic                             rst_n        = 1'b0;
    logic                             in_valid     = 1'b0;
    logic [tmsa_pkg::SAMPLE_BITS-1:0] sample       = '0;
    logic                             cfg_valid    = 1'b0;
    logic [tmsa_pkg::COUNT_BITS-1:0]  sample_count = tmsa_pkg::SAMPLE_COUNT_RESET;
    logic                             out_stall    = 1'b0;
    logic                             long_hold_go = 1'b0;
    wire                              in_stall;
    wire                              cfg_ready;
    wire                              out_valid;
    wire [tmsa_pkg::AVG_BITS-1:0]     average;
    wire                              no_valid_samples;

    int unsigned error_count;
    int unsigned pending_results;
    int unsigned burst_left = 0;
    int unsigned gap_max    = 0;

    trimmed_mean_sample_averager dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .sample           (sample),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .sample_count     (sample_count),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .average          (average),
        .no_valid_samples (no_valid_samples)
    );

    trimmed_mean_checker checker_i (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .sample           (sample),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .sample_count     (sample_count),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .average          (average),
        .no_valid_samples (no_valid_samples),
        .error_count      (error_count),
        .pending_results  (pending_results)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #(5_000_000);
        $display("** trimmed_mean_sample_averager: FAILED **");
        $finish;
    end

    task automatic send_sample(input logic [tmsa_pkg::SAMPLE_BITS-1:0] v);
        int unsigned gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, gap_max);
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        in_valid <= 1'b1;
        sample   <= v;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic wait_for_drain();
        @(posedge clk);
        while (pending_results != 0)
            @(posedge clk);
    endtask

    task automatic set_sample_count(input logic [tmsa_pkg::COUNT_BITS-1:0] v);
        in_valid <= 1'b0;
        wait_for_drain();
        repeat (30) @(posedge clk);
        cfg_valid    <= 1'b1;
        sample_count <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin : receiver
        int unsigned run_len;
        int unsigned stall_pct;
        int unsigned i;
        logic        long_hold_done;
        long_hold_done = 1'b0;
        @(posedge clk);
        forever
        begin
            if (long_hold_go && !long_hold_done)
            begin
                // long hold while requests keep coming
                long_hold_done = 1'b1;
                out_stall <= 1'b1;
                repeat (300) @(posedge clk);
            end
            else
            begin
                case ($urandom_range(0, 2))
                    0:       stall_pct = 0;
                    1:       stall_pct = 30;
                    default: stall_pct = 80;
                endcase
                run_len = $urandom_range(10, 80);
                i = 0;
                while (i < run_len && !(long_hold_go && !long_hold_done))
                begin
                    out_stall <= ($urandom_range(0, 99) < stall_pct);
                    @(posedge clk);
                    i++;
                end
            end
        end
    end

    initial
    begin : stimulus
        logic [tmsa_pkg::SAMPLE_BITS-1:0] directed [12];
        logic [tmsa_pkg::COUNT_BITS-1:0]  phase_count [9];
        logic [tmsa_pkg::SAMPLE_BITS-1:0] v;
        int unsigned                      n_items;
        int unsigned                      zero_pct;
        int unsigned                      roll;
        int unsigned                      p;
        int unsigned                      k;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // warm-up extremes, then a mixed batch at the reset count
        gap_max  = 2;
        directed = '{12'd4095, 12'd0, 12'd1, 12'd2048, 12'd4095, 12'd1, 12'd0, 12'd2730,
                     12'd1365, 12'd4095, 12'd1, 12'd100};
        foreach (directed[i])
            send_sample(directed[i]);
        // zero count taken as one, batch with no valid sample
        set_sample_count(8'd0);
        repeat (5) send_sample('0);
        // single valid sample with trimming saturates to zero
        set_sample_count(8'd3);
        repeat (4) send_sample('1);
        send_sample('0);
        send_sample('1);
        send_sample('0);

        phase_count = '{8'd2, 8'd1, 8'd0, 8'd255, 8'd3, 8'd0, 8'd0, 8'd0, 8'd8};
        for (p = 5; p < 8; p++)
            phase_count[p] = tmsa_pkg::COUNT_BITS'($urandom_range(3, 20));

        for (p = 0; p < 9; p++)
        begin
            set_sample_count(phase_count[p]);
            case ($urandom_range(0, 2))
                0:       gap_max = 0;
                1:       gap_max = 3;
                default: gap_max = 8;
            endcase
            if (p == 1)
            begin
                long_hold_go <= 1'b1;
                gap_max = 0;
            end
            case ($urandom_range(0, 2))
                0:       zero_pct = 3;
                1:       zero_pct = 25;
                default: zero_pct = 85;
            endcase
            n_items = (phase_count[p] == 8'd255) ? 259 : $urandom_range(40, 80);
            for (k = 0; k < n_items; k++)
            begin
                roll = $urandom_range(0, 99);
                if (roll < zero_pct)
                    v = '0;
                else if (roll < zero_pct + 8)
                    v = '1;
                else if (roll < zero_pct + 16)
                    v = tmsa_pkg::SAMPLE_BITS'($urandom_range(1, 15));
                else
                    v = tmsa_pkg::SAMPLE_BITS'($urandom_range(1, 4095));
                send_sample(v);
            end
        end

        in_valid <= 1'b0;
        wait_for_drain();
        repeat (40) @(posedge clk);
        if (error_count == 0 && pending_results == 0)
            $display("** trimmed_mean_sample_averager: PASSED **");
        else
            $display("** trimmed_mean_sample_averager: FAILED **");
        $finish;
    end

endmodule

@@ trimmed_mean_sample_averager.f @@
src/tmsa_pkg.sv
src/tmsa_div.sv
src/trimmed_mean_sample_averager.sv
dv/trimmed_mean_checker.sv
dv/tb_trimmed_mean_sample_averager.sv
